// ===== src/cfdtx_pkg.sv =====
// ----------------------------------------------------------------------------
// cfdtx_pkg
// Shared constants and DLC helpers for the CAN FD transmit buffer packer.
// ----------------------------------------------------------------------------
package cfdtx_pkg;

	localparam int MB_WORDS   = 18;
	localparam int DATA_WORDS = MB_WORDS - 2;
	localparam int CAP_BYTES  = (4 * DATA_WORDS < 64) ? 4 * DATA_WORDS : 64;

	localparam logic [7:0]  PAD_BYTE        = 8'h30;
	localparam logic [31:0] CS_FD_BASE      = 32'h8C40_0000;
	localparam logic [31:0] CS_CLASSIC_BASE = 32'h0C40_0000;

	// configuration register indexes
	localparam logic [1:0] CFG_FD_ENABLE  = 2'd0;
	localparam logic [1:0] CFG_BRS_ENABLE = 2'd1;
	localparam logic [1:0] CFG_DEVICE_ID  = 2'd2;

	// buffer word indexes
	localparam logic [4:0] IDX_CS    = 5'd0;
	localparam logic [4:0] IDX_ID    = 5'd1;
	localparam logic [4:0] IDX_DATA0 = 5'd2;

	typedef logic [6:0] count_t;

	function automatic count_t dlc_length(input logic [3:0] dlc);
		count_t len;
		case (dlc)
			4'd9:    len = 7'd12;
			4'd10:   len = 7'd16;
			4'd11:   len = 7'd20;
			4'd12:   len = 7'd24;
			4'd13:   len = 7'd32;
			4'd14:   len = 7'd48;
			4'd15:   len = 7'd64;
			default: len = {3'b000, dlc};
		endcase
		return len;
	endfunction

	// smallest DLC whose length covers len
	function automatic logic [3:0] dlc_for_len(input count_t len);
		logic [3:0] dlc;
		dlc = 4'd15;
		for (int i = 15; i >= 0; i--) begin
			if (len <= dlc_length(4'(i)))
				dlc = 4'(i);
		end
		return dlc;
	endfunction

endpackage

// ===== src/can_fd_tx_buffer_packer.sv =====
// ----------------------------------------------------------------------------
// can_fd_tx_buffer_packer
// Packs payload bytes big-endian into message-buffer data words and closes
// each message with padding words, the standard-ID word and the CS word.
// ----------------------------------------------------------------------------
// Path: an accepted item is held in the input register, and each word it
// causes is then registered in the output register.
// Throughput: one payload byte per cycle unless the output stalls. A finish
// holds the input stage while it emits the open data words, ID word and CS word.
// Reset: arst_n clears the packing state and loads fd_enable=1, brs_enable=0,
// node ID 0.
module can_fd_tx_buffer_packer import cfdtx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [7:0]  cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // data_byte[7:0], mtype[10:8], zero
	input  logic [0:0]  s_axis_tuser,   // mode[0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // word_index[4:0], word_value[36:5], zero
	output logic        m_axis_tlast,
	output logic [0:0]  m_axis_tuser    // overflow[0]
);

	logic        fd_en_q;
	logic        brs_en_q;
	logic [7:0]  dev_id_q;

	logic        item_valid_s1;
	logic        mode_s1;
	logic [7:0]  byte_s1;
	logic [2:0]  mtype_s1;

	count_t      byte_count_q;
	logic [23:0] partial_q;
	logic        overflow_q;
	logic [2:0]  step_q;

	logic        out_valid_q;
	logic [4:0]  out_index_q;
	logic [31:0] out_value_q;
	logic        out_last_q;
	logic        out_ovf_q;

	logic        out_free;
	logic        in_take;
	logic        item_done;

	logic        app_drop;
	logic [1:0]  app_pos;
	logic        app_emit;

	logic [3:0]  fin_dlc;
	count_t      fin_target;
	logic [4:0]  fin_end_full;
	logic [4:0]  fin_end;
	logic [4:0]  fin_start;
	logic [4:0]  fin_nd;
	logic [4:0]  fin_word;
	logic [31:0] fin_data;
	logic [31:0] fin_cs;
	logic [31:0] pend_word;
	logic        step_data;
	logic        step_id;
	logic        step_cs;

	logic        gen_valid;
	logic [4:0]  gen_index;
	logic [31:0] gen_value;
	logic        gen_last;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign in_take       = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !item_valid_s1 || item_done;

	// append path
	assign app_drop = byte_count_q >= 7'(CAP_BYTES);
	assign app_pos  = byte_count_q[1:0];
	assign app_emit = !app_drop && (app_pos == 2'd3);

	// finish path: data words from the open word up to the DLC length
	assign fin_dlc      = dlc_for_len(byte_count_q);
	assign fin_target   = dlc_length(fin_dlc);
	assign fin_end_full = 5'((fin_target + 7'd3) >> 2);
	assign fin_end      = (fin_end_full > 5'(DATA_WORDS)) ? 5'(DATA_WORDS) : fin_end_full;
	assign fin_start    = byte_count_q[6:2];
	assign fin_nd       = (fin_end > fin_start) ? (fin_end - fin_start) : 5'd0;
	assign fin_word     = fin_start + 5'(step_q);
	assign pend_word    = {partial_q, 8'h00};

	assign step_data = {2'b00, step_q} < fin_nd;
	assign step_id   = {2'b00, step_q} == fin_nd;
	assign step_cs   = !step_data && !step_id;

	always_comb begin
		logic [6:0] p;
		for (int j = 0; j < 4; j++) begin
			p = {fin_word, 2'(j)};
			if (p < byte_count_q)
				fin_data[31 - 8 * j -: 8] = pend_word[31 - 8 * j -: 8];
			else if (p < fin_target)
				fin_data[31 - 8 * j -: 8] = PAD_BYTE;
			else
				fin_data[31 - 8 * j -: 8] = 8'h00;
		end
	end

	always_comb begin
		if (fd_en_q)
			fin_cs = CS_FD_BASE | {1'b0, brs_en_q, 30'd0} | {12'd0, fin_dlc, 16'd0};
		else
			fin_cs = CS_CLASSIC_BASE | {12'd0, fin_dlc, 16'd0};
	end

	always_comb begin
		gen_valid = 1'b0;
		gen_index = IDX_CS;
		gen_value = fin_cs;
		gen_last  = 1'b0;
		if (item_valid_s1) begin
			if (!mode_s1) begin
				gen_valid = app_emit;
				gen_index = IDX_DATA0 + byte_count_q[6:2];
				gen_value = {partial_q, byte_s1};
			end else begin
				gen_valid = 1'b1;
				if (step_data) begin
					gen_index = IDX_DATA0 + fin_word;
					gen_value = fin_data;
				end else if (step_id) begin
					gen_index = IDX_ID;
					gen_value = {3'b000, mtype_s1, dev_id_q, 18'd0};
				end else begin
					gen_last  = 1'b1;
				end
			end
		end
	end

	assign item_done = item_valid_s1 &&
		(mode_s1 ? (step_cs && out_free) : (!app_emit || out_free));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fd_en_q  <= 1'b1;
			brs_en_q <= 1'b0;
			dev_id_q <= 8'd0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_FD_ENABLE:  fd_en_q  <= cfg_wdata[0];
				CFG_BRS_ENABLE: brs_en_q <= cfg_wdata[0];
				CFG_DEVICE_ID:  dev_id_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (in_take) begin
			item_valid_s1 <= 1'b1;
		end else if (item_done) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			mode_s1  <= s_axis_tuser[0];
			byte_s1  <= s_axis_tdata[7:0];
			mtype_s1 <= s_axis_tdata[10:8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			partial_q    <= '0;
			overflow_q   <= 1'b0;
			step_q       <= '0;
		end else begin
			if (item_valid_s1 && mode_s1 && out_free)
				step_q <= step_cs ? 3'd0 : step_q + 3'd1;
			if (item_done) begin
				if (mode_s1) begin
					byte_count_q <= '0;
					partial_q    <= '0;
					overflow_q   <= 1'b0;
				end else if (app_drop) begin
					overflow_q <= 1'b1;
				end else begin
					byte_count_q <= byte_count_q + 7'd1;
					if (app_pos == 2'd3)
						partial_q <= '0;
					else
						partial_q <= partial_q |
							(24'(byte_s1) << (5'd16 - {app_pos, 3'b000}));
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= gen_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && gen_valid) begin
			out_index_q <= gen_index;
			out_value_q <= gen_value;
			out_last_q  <= gen_last;
			out_ovf_q   <= overflow_q;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = {3'b000, out_value_q, out_index_q};
	assign m_axis_tlast    = out_last_q;
	assign m_axis_tuser[0] = out_ovf_q;

endmodule

// ===== src/cfdtx_checker.sv =====
// ----------------------------------------------------------------------------
// cfdtx_checker
// Port-level checks for the CAN FD transmit buffer packer.
// ----------------------------------------------------------------------------
module cfdtx_checker import cfdtx_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic        m_axis_tlast,
	input logic [0:0]  m_axis_tuser
);

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tlast) && $stable(m_axis_tuser))
		else $error("output word changed while stalled");

	// the closing word is always the CS word
	a_last_is_cs: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[4:0] == IDX_CS)
		else $error("tlast on a word other than CS");

	a_cs_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[4:0] == IDX_CS |-> m_axis_tlast)
		else $error("CS word without tlast");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[4:0] < 5'(MB_WORDS))
		else $error("word index beyond message buffer");

endmodule

bind can_fd_tx_buffer_packer cfdtx_checker u_cfdtx_checker (.*);

// ===== dv/tb_can_fd_tx_buffer_packer.sv =====
// ----------------------------------------------------------------------------
// tb_can_fd_tx_buffer_packer
// Self-checking bench for the CAN FD transmit buffer packer. It streams payload
// bytes and finish words with random gaps and backpressure, and predicts every
// buffer word: packed data, 0x30 padding up to the DLC length, the ID word and
// the CS word. It scoreboards the output in order and reprograms the
// configuration registers between idle phases.
// ----------------------------------------------------------------------------
module tb_can_fd_tx_buffer_packer;
	import cfdtx_pkg::*;

	localparam logic MODE_BYTE   = 1'b0;
	localparam logic MODE_FINISH = 1'b1;
	localparam int   DLC_LEN [16] = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 12, 16, 20, 24, 32, 48, 64};

	typedef struct packed {
		logic       mode;
		logic [7:0] data;
		logic [2:0] mtype;
	} tx_item_t;

	typedef struct {
		logic [4:0]  idx;
		logic [31:0] val;
		logic        last;
		logic        ovf;
	} mb_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_addr = '0;
	logic [7:0]  cfg_wdata = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic [0:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic [0:0]  m_axis_tuser;

	// predictor state and its copy of the registers
	logic [6:0]  fill_cnt = '0;
	logic [23:0] held_bytes = '0;
	logic        ovf_seen = 1'b0;
	logic        fd_en = 1'b1;
	logic        brs_en = 1'b0;
	logic [7:0]  dev_id = '0;

	tx_item_t    pend_q[$];
	tx_item_t    in_flight;
	mb_word_t    buf_words_q[$];

	bit          calm = 1'b0;
	int unsigned queued_cnt = 0;
	int unsigned accepted_cnt = 0;
	int unsigned msg_cnt = 0;
	int unsigned ovf_msg_cnt = 0;
	int unsigned word_cnt = 0;
	int unsigned err_cnt = 0;

	can_fd_tx_buffer_packer DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void expect_word(input logic [4:0] idx, input logic [31:0] val,
			input logic last);
		mb_word_t w;
		w.idx  = idx;
		w.val  = val;
		w.last = last;
		w.ovf  = ovf_seen;
		buf_words_q.push_back(w);
	endfunction

	// data words past the end of the buffer are never written
	function automatic void expect_data(input logic [4:0] wrd, input logic [31:0] val);
		if (int'(wrd) + 2 < MB_WORDS)
			expect_word(IDX_DATA0 + wrd, val, 1'b0);
	endfunction

	function automatic void pack_item(input tx_item_t it);
		logic [6:0]  len;
		logic [6:0]  b;
		logic [6:0]  target;
		logic [3:0]  dlc;
		logic [4:0]  wrd;
		logic [31:0] cur;
		logic [31:0] cs;
		if (it.mode == MODE_BYTE) begin
			if (int'(fill_cnt) >= CAP_BYTES) begin
				ovf_seen = 1'b1;
			end else begin
				if (fill_cnt[1:0] == 2'd3) begin
					expect_data(fill_cnt[6:2], {held_bytes, it.data});
					held_bytes = '0;
				end else
					held_bytes[(23 - 8 * fill_cnt[1:0]) -: 8] = it.data;
				fill_cnt = fill_cnt + 7'd1;
			end
		end else begin
			len = fill_cnt;
			dlc = 4'd15;
			for (int i = 15; i >= 0; i--)
				if (int'(len) <= DLC_LEN[i])
					dlc = 4'(i);
			target = 7'(DLC_LEN[dlc]);
			b = len;
			wrd = len[6:2];
			cur = (len[1:0] != 2'd0) ? {held_bytes, 8'h00} : 32'h0;
			while (b < target) begin
				cur = cur | (32'(PAD_BYTE) << (24 - 8 * b[1:0]));
				b = b + 7'd1;
				if (b[1:0] == 2'd0) begin
					expect_data(wrd, cur);
					wrd = wrd + 5'd1;
					cur = '0;
				end
			end
			if (b[1:0] != 2'd0)
				expect_data(wrd, cur);
			expect_word(IDX_ID, {3'b000, it.mtype, dev_id, 18'h0}, 1'b0);
			if (fd_en)
				cs = CS_FD_BASE | {1'b0, brs_en, 30'h0} | (32'(dlc) << 16);
			else
				cs = CS_CLASSIC_BASE | (32'(dlc) << 16);
			expect_word(IDX_CS, cs, 1'b1);
			msg_cnt++;
			if (ovf_seen)
				ovf_msg_cnt++;
			fill_cnt = '0;
			held_bytes = '0;
			ovf_seen = 1'b0;
		end
	endfunction

	// source side: holds the word until it is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				pack_item(in_flight);
				accepted_cnt++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pend_q.size() != 0 && (calm || $urandom_range(99) >= 36)) begin
					in_flight = pend_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {5'b00000, in_flight.mtype, in_flight.data};
					s_axis_tuser <= in_flight.mode;
				end else
					s_axis_tvalid <= 1'b0;
			end
		end
	end

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t: %s mismatch, expected %h, got %h", $realtime, name, exp_v, got_v);
			err_cnt++;
		end
	endtask

	// sink side: random backpressure, in-order compare
	always @(posedge clk or negedge arst_n) begin
		mb_word_t e;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (buf_words_q.size() == 0) begin
					$display("%0t: unexpected word, expected none, got index %0d value %h",
						$realtime, m_axis_tdata[4:0], m_axis_tdata[36:5]);
					err_cnt++;
				end else begin
					e = buf_words_q.pop_front();
					check_field("word_index", 32'(e.idx), 32'(m_axis_tdata[4:0]));
					check_field("word_value", e.val, m_axis_tdata[36:5]);
					check_field("last_of_run", 32'(e.last), 32'(m_axis_tlast));
					check_field("overflow", 32'(e.ovf), 32'(m_axis_tuser[0]));
					word_cnt++;
				end
			end
			m_axis_tready <= calm || ($urandom_range(99) >= 36);
		end
	end

	task automatic queue_item(input logic mode, input logic [7:0] data, input logic [2:0] mtype);
		tx_item_t it;
		it.mode = mode;
		it.data = data;
		it.mtype = mtype;
		pend_q.push_back(it);
		queued_cnt++;
	endtask

	task automatic queue_message(input int n_bytes);
		for (int i = 0; i < n_bytes; i++)
			queue_item(MODE_BYTE, 8'($urandom), 3'($urandom));
		queue_item(MODE_FINISH, 8'($urandom), 3'($urandom));
	endtask

	// wait for the stream to drain, then let trailing byte words clear the pipe
	task automatic settle();
		while (accepted_cnt != queued_cnt || buf_words_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic program_regs(input logic fd, input logic brs, input logic [7:0] dev);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= CFG_FD_ENABLE;
		cfg_wdata <= {7'b0, fd};
		@(posedge clk);
		cfg_addr <= CFG_BRS_ENABLE;
		cfg_wdata <= {7'b0, brs};
		@(posedge clk);
		cfg_addr <= CFG_DEVICE_ID;
		cfg_wdata <= dev;
		@(posedge clk);
		cfg_we <= 1'b0;
		fd_en = fd;
		brs_en = brs;
		dev_id = dev;
	endtask

	initial begin
		int unsigned phase_start;
		int r;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed, reset register values
		queue_item(MODE_FINISH, 8'hFF, 3'd7);
		queue_item(MODE_BYTE, 8'hFF, 3'd7);
		queue_item(MODE_FINISH, 8'h00, 3'd0);
		queue_item(MODE_BYTE, 8'h00, 3'd7);
		queue_item(MODE_BYTE, 8'hFF, 3'd0);
		queue_item(MODE_BYTE, 8'hA5, 3'd2);
		queue_item(MODE_BYTE, 8'h5A, 3'd5);
		queue_item(MODE_FINISH, 8'h5A, 3'd5);
		for (int i = 1; i <= 7; i++)
			queue_item(MODE_BYTE, 8'(i * 8'h25), 3'd0);
		queue_item(MODE_FINISH, 8'h00, 3'd3);
		for (int i = 1; i <= 9; i++)
			queue_item(MODE_BYTE, 8'(i), 3'd1);
		queue_item(MODE_FINISH, 8'hC3, 3'd2);
		settle();

		for (int ph = 1; ph <= 5; ph++) begin
			case (ph)
				1: program_regs(1'b0, 1'b1, 8'hFF);
				2: program_regs(1'b1, 1'b1, 8'h00);
				3: begin
					calm = 1'b1;
					program_regs(1'b1, 1'b0, 8'($urandom));
				end
				4: program_regs(1'b0, 1'b0, 8'($urandom));
				default: program_regs(1'b1, 1'b1, 8'($urandom));
			endcase
			phase_start = queued_cnt;
			if (ph == 1)
				queue_message(66);
			while (queued_cnt - phase_start < 45) begin
				// stray finish now and then: an empty message
				if ($urandom_range(9) == 0)
					queue_item(MODE_FINISH, 8'($urandom), 3'($urandom));
				r = $urandom_range(99);
				if (r < 35)
					queue_message($urandom_range(8));
				else if (r < 60)
					queue_message($urandom_range(24, 9));
				else if (r < 75)
					queue_message($urandom_range(48, 25));
				else if (r < 85)
					queue_message($urandom_range(64, 49));
				else
					queue_message($urandom_range(70, 65));
			end
			settle();
			calm = 1'b0;
		end

		$display("Covered %0d items in %0d messages (%0d with dropped bytes), %0d words checked,",
			accepted_cnt, msg_cnt, ovf_msg_cnt, word_cnt);
		$display("over six register settings including FD/classic and BRS on/off.");
		if (err_cnt == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#400000;
		$display("Run timed out");
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
